@@ rtl/core/tab_control_char_expander_assert.svh @@
// Assertion macros shared by the checker of the tab and control character expander.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef TAB_CONTROL_CHAR_EXPANDER_ASSERT_SVH
`define TAB_CONTROL_CHAR_EXPANDER_ASSERT_SVH

// Assertion that is switched off while the synchronous reset is active.
`define TCE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define TCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/tce_pkg.sv @@
// Package of the tab and control character expander: widths, character codes,
// register indexes, result kinds and the command and status structs.
// It depends on nothing else.
package tce_pkg;

    localparam int CHAR_W   = 8;
    localparam int COL_W    = 8;
    localparam int TAB_W    = 5;
    localparam int SUM_W    = 10;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DCNT_W   = $clog2(COL_W);

    localparam int RESULT_LIMIT = 16;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_CARET = 8'd94;
    localparam logic [CHAR_W-1:0] CTRL_LIMIT = 8'd32;
    localparam logic [CHAR_W-1:0] CTRL_OFFSET = 8'd64;
    localparam logic [TAB_W-1:0]  CTRL_SCREEN_STEP = 5'd2;
    localparam logic [TAB_W-1:0]  CARET_RESULTS = 5'd2;

    localparam logic [TAB_W-1:0]  TAB_WIDTH_RST  = 5'd8;
    localparam logic [COL_W-1:0]  LINE_WIDTH_RST = 8'd79;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAB_WIDTH    = 2'd0,
        CFG_PRINTER_MODE = 2'd1,
        CFG_REVERSE_TABS = 2'd2,
        CFG_LINE_WIDTH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        K_STOP,
        K_TAB,
        K_CARET,
        K_CTRL,
        K_PLAIN
    } t_kind;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic eval;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/tce_datapath.sv @@
// Datapath of the tab and control character expander: configuration registers, line
// state, bit-serial remainder unit for tab stops, result counter and output register.
// Depends on tce_pkg and is sequenced by tce_controller.
module tce_datapath #(
    parameter int MAX_TAB = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tce_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [tce_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                          i_first_of_line,
    input  logic [tce_pkg::COL_W-1:0]     i_start_offset,
    input  tce_pkg::t_cmd                 i_cmd,
    output tce_pkg::t_status              o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tce_pkg::CHAR_W-1:0]    o_out_char,
    output logic                          o_char_valid,
    output logic                          o_reverse_video,
    output logic                          o_line_done,
    output logic [tce_pkg::COL_W-1:0]     o_column_now,
    output logic                          o_last_of_run
);
    import tce_pkg::*;

    localparam int TAB_LIM_I = (MAX_TAB > RESULT_LIMIT) ? RESULT_LIMIT :
                               ((MAX_TAB < 1) ? 1 : MAX_TAB);
    localparam logic [TAB_W-1:0] TAB_LIM = TAB_W'(TAB_LIM_I);

    logic [TAB_W-1:0]  r_tab_width;
    logic              r_printer_mode;
    logic              r_reverse_tabs;
    logic [COL_W-1:0]  r_line_width;

    logic [COL_W-1:0]  r_column, n_column;
    logic [COL_W-1:0]  r_offset, n_offset;
    logic              r_stopped, n_stopped;
    logic [CHAR_W-1:0] r_char;
    logic [TAB_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [TAB_W-1:0]  r_cnt;
    t_kind             r_kind;
    logic              r_out_valid;

    logic [TAB_W-1:0]  eff_tab;
    logic [COL_W-1:0]  b_column;
    logic [COL_W-1:0]  b_offset;
    logic              b_stopped;
    logic [CHAR_W-1:0] e_char;
    logic [TAB_W-1:0]  e_step;
    logic [SUM_W-1:0]  e_sum;
    t_kind             e_kind;
    logic [TAB_W-1:0]  e_cnt;
    logic [DCNT_W-1:0] div_bit;
    logic [TAB_W-1:0]  rem_shift;
    logic [TAB_W-1:0]  rem_next;

    always_comb begin
        eff_tab = r_tab_width;
        if (eff_tab == '0) begin
            eff_tab = TAB_W'(1);
        end
        if (eff_tab > TAB_LIM) begin
            eff_tab = TAB_LIM;
        end
    end

    // Values that hold once a first-of-line item has reset the line.
    always_comb begin
        b_column  = r_column;
        b_offset  = r_offset;
        b_stopped = r_stopped;
        if (i_cmd.accept && i_first_of_line) begin
            b_column  = '0;
            b_offset  = i_start_offset;
            b_stopped = 1'b0;
        end
    end

    assign e_char = i_cmd.accept ? i_char_code : r_char;

    always_comb begin
        if (e_char == CHAR_TAB) begin
            e_step = eff_tab - r_rem;
        end else if (e_char < CTRL_LIMIT && !r_printer_mode) begin
            e_step = CTRL_SCREEN_STEP;
        end else begin
            e_step = TAB_W'(1);
        end
        e_sum = SUM_W'(b_column) + SUM_W'(e_step) + SUM_W'(b_offset);
    end

    always_comb begin
        e_cnt = TAB_W'(1);
        if (b_stopped || e_char == CHAR_CR || e_char == CHAR_NUL) begin
            e_kind = K_STOP;
        end else if (e_sum > SUM_W'(r_line_width)) begin
            e_kind = K_STOP;
        end else if (e_char == CHAR_TAB) begin
            e_kind = K_TAB;
            e_cnt  = e_step;
        end else if (e_char < CTRL_LIMIT) begin
            if (r_printer_mode) begin
                e_kind = K_CARET;
                e_cnt  = CARET_RESULTS;
            end else begin
                e_kind = K_CTRL;
            end
        end else begin
            e_kind = K_PLAIN;
        end
    end

    always_comb begin
        n_column  = b_column;
        n_offset  = b_offset;
        n_stopped = b_stopped;
        if (i_cmd.eval) begin
            if (e_kind == K_STOP) begin
                n_stopped = 1'b1;
            end else begin
                n_column = b_column + COL_W'(e_step);
            end
        end
    end

    // Restoring remainder step, one column bit per cycle, most significant first.
    always_comb begin
        div_bit   = DCNT_W'(COL_W - 1) - r_dcnt;
        rem_shift = {r_rem[TAB_W-2:0], r_column[div_bit]};
        rem_next  = (rem_shift >= eff_tab) ? (rem_shift - eff_tab) : rem_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_width    <= TAB_WIDTH_RST;
            r_printer_mode <= 1'b0;
            r_reverse_tabs <= 1'b0;
            r_line_width   <= LINE_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TAB_WIDTH:    r_tab_width    <= i_cfg_data[TAB_W-1:0];
                CFG_PRINTER_MODE: r_printer_mode <= i_cfg_data[0];
                CFG_REVERSE_TABS: r_reverse_tabs <= i_cfg_data[0];
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[COL_W-1:0];
                default:          r_line_width   <= r_line_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_offset    <= '0;
            r_stopped   <= 1'b0;
            r_cnt       <= '0;
            r_kind      <= K_STOP;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_rem       <= '0;
        end else begin
            r_column  <= n_column;
            r_offset  <= n_offset;
            r_stopped <= n_stopped;
            if (i_cmd.accept) begin
                r_rem  <= '0;
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_rem  <= rem_next;
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            if (i_cmd.eval) begin
                r_kind <= e_kind;
                r_cnt  <= e_cnt;
            end else if (i_cmd.emit) begin
                r_cnt <= r_cnt - TAB_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char <= i_char_code;
        end
        if (i_cmd.emit) begin
            o_column_now  <= r_column;
            o_last_of_run <= (r_cnt == TAB_W'(1));
            unique case (r_kind)
                K_STOP: begin
                    o_out_char      <= '0;
                    o_char_valid    <= 1'b0;
                    o_reverse_video <= 1'b0;
                    o_line_done     <= 1'b1;
                end
                K_TAB: begin
                    o_out_char      <= CHAR_SPACE;
                    o_char_valid    <= 1'b1;
                    o_reverse_video <= !r_printer_mode && r_reverse_tabs;
                    o_line_done     <= 1'b0;
                end
                K_CARET: begin
                    o_out_char      <= (r_cnt == CARET_RESULTS) ? CHAR_CARET
                                                                : r_char + CTRL_OFFSET;
                    o_char_valid    <= 1'b1;
                    o_reverse_video <= 1'b0;
                    o_line_done     <= 1'b0;
                end
                K_CTRL: begin
                    o_out_char      <= r_char + CTRL_OFFSET;
                    o_char_valid    <= 1'b1;
                    o_reverse_video <= 1'b1;
                    o_line_done     <= 1'b0;
                end
                K_PLAIN: begin
                    o_out_char      <= r_char;
                    o_char_valid    <= 1'b1;
                    o_reverse_video <= 1'b0;
                    o_line_done     <= 1'b0;
                end
                default: begin
                    o_out_char      <= '0;
                    o_char_valid    <= 1'b0;
                    o_reverse_video <= 1'b0;
                    o_line_done     <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.need_div  = (i_char_code == CHAR_TAB) && !b_stopped;
    assign o_status.div_last  = (r_dcnt == DCNT_W'(COL_W - 1));
    assign o_status.emit_last = (r_cnt == TAB_W'(1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

endmodule

@@ rtl/core/tce_controller.sv @@
// Controller of the tab and control character expander: a state machine that takes an
// item, runs the tab stop remainder for a tab, evaluates the byte and sends its results.
// Depends on tce_pkg and drives tce_datapath through command and status structs.
module tce_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tce_pkg::t_status i_status,
    output tce_pkg::t_cmd    o_cmd
);
    import tce_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EVAL,
        S_EMIT
    } t_state;

    t_state r_state;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.div_step  = (r_state == S_DIV);
    assign o_cmd.eval      = (o_cmd.accept && !i_status.need_div) || (r_state == S_EVAL);
    assign o_cmd.emit      = (r_state == S_EMIT) && i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= i_status.need_div ? S_DIV : S_EMIT;
                    end
                end
                S_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_status.out_free && i_status.emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/tab_control_char_expander.sv @@
// A printable or control byte is evaluated in the cycle it is taken; a tab on a line that
// has not stopped first runs the bit-serial remainder over the column bits and then an
// evaluation state. Results leave through the single output register, which sets their
// pace; a new item is taken only after the last result of the previous one has been sent.
// Reset is synchronous and active low; it restores the register defaults and clears
// the column, the line offset, the stopped flag and the output valid.
module tab_control_char_expander #(
    parameter int MAX_TAB = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // char_code, start_offset
    input  logic [0:0]  s_axis_tuser,  // first_of_line
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // out_char, column_now
    output logic [2:0]  m_axis_tuser,  // char_valid, reverse_video, line_done
    output logic        m_axis_tlast
);
    import tce_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [CHAR_W-1:0] out_char;
    logic [COL_W-1:0]  column_now;
    logic              char_valid;
    logic              reverse_video;
    logic              line_done;

    tce_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tce_datapath #(
        .MAX_TAB (MAX_TAB)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_char_code     (s_axis_tdata[7:0]),
        .i_first_of_line (s_axis_tuser[0]),
        .i_start_offset  (s_axis_tdata[15:8]),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out_char      (out_char),
        .o_char_valid    (char_valid),
        .o_reverse_video (reverse_video),
        .o_line_done     (line_done),
        .o_column_now    (column_now),
        .o_last_of_run   (m_axis_tlast)
    );

    assign m_axis_tdata = {column_now, out_char};
    assign m_axis_tuser = {line_done, reverse_video, char_valid};

endmodule

@@ rtl/core/tce_checker.sv @@
// Port-level checker of the tab and control character expander, bound to the top level.
// Depends on the assertion macros in tab_control_char_expander_assert.svh.
`include "tab_control_char_expander_assert.svh"

module tce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    `TCE_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "item dropped while stalled")
    `TCE_ASSERT_RST(a_done_single, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[0] && m_axis_tlast, "line end item must be a lone hidden item")
    `TCE_ASSERT_RST(a_rev_shown, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0], "reverse video on a hidden item")
    `TCE_ASSERT_RST(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "next item taken before results were sent")
    `TCE_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

endmodule

bind tab_control_char_expander tce_checker u_tce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
